@@ hdl/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, widths and the month-length table for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

    localparam int DAYS_WIDTH  = 16;
    // Remaining count can grow by up to 30 when the start day is past month end.
    localparam int LEFT_WIDTH  = DAYS_WIDTH + 1;
    localparam int MONTH_WIDTH = 4;
    localparam int DAY_WIDTH   = 5;
    localparam int YEAR_WIDTH  = 14;
    localparam int QUOT_WIDTH  = 8;   // year / 100 is at most 163
    localparam int YMOD_WIDTH  = 7;   // year % 100

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y
    localparam int DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int PROD_WIDTH = YEAR_WIDTH + 13;

    localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;
    localparam logic [YEAR_WIDTH-1:0]  YEAR_MAX  = '1;
    localparam logic [YMOD_WIDTH-1:0]  YMOD_LAST = 7'd99;

    typedef struct packed {
        logic load;   // capture the start date and count
        logic div;    // year / 100
        logic rem;    // year % 100 and century mod 4
        logic step;   // advance one month or finish the day
    } gdad_cmd_t;

    typedef struct packed {
        logic left_zero;
    } gdad_status_t;

    function automatic logic [DAY_WIDTH-1:0] month_length(
        input logic [MONTH_WIDTH-1:0] month,
        input logic                   leap
    );
        logic [DAY_WIDTH-1:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/gregorian_date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds a day count to a Gregorian date, walking one month per cycle.
// ----------------------------------------------------------------------------
// A date is taken when start is high and busy is low. The block then splits
// the year into year mod 100 and century mod 4 (in the DIV and REM states,
// one constant multiply each), walks the count one month per cycle through
// the month-step loop, and raises done for exactly one cycle with end_month,
// end_day and end_year valid in that cycle. The walk takes one step per
// month end crossed, plus one more when the count runs out inside a month,
// and none for a zero count; busy falls the cycle after done. The result is
// not held: the receiver must take it in the done cycle.
module gregorian_date_add_days_unit
    import gdad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [MONTH_WIDTH-1:0] start_month,
    input  logic [DAY_WIDTH-1:0]   start_day,
    input  logic [YEAR_WIDTH-1:0]  start_year,
    input  logic [DAYS_WIDTH-1:0]  day_count,
    output logic                   done,
    output logic [MONTH_WIDTH-1:0] end_month,
    output logic [DAY_WIDTH-1:0]   end_day,
    output logic [YEAR_WIDTH-1:0]  end_year
);

    gdad_cmd_t    cmd;
    gdad_status_t status;

    gdad_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    gdad_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .start_month (start_month),
        .start_day   (start_day),
        .start_year  (start_year),
        .day_count   (day_count),
        .end_month   (end_month),
        .end_day     (end_day),
        .end_year    (end_year)
    );

endmodule

@@ hdl/gdad_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: load, year split, month walk, one-cycle result strobe.
// ----------------------------------------------------------------------------
module gdad_ctrl
    import gdad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output logic         done,
    output gdad_cmd_t    cmd,
    input  gdad_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_REM  = 5'b00100,
        ST_WALK = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.left_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

@@ hdl/gdad_dp.sv @@
// ----------------------------------------------------------------------------
// gdad_dp
// Date registers, year-mod counters and the one-month step logic.
// ----------------------------------------------------------------------------
module gdad_dp
    import gdad_pkg::*;
(
    input  logic                   clk,
    input  gdad_cmd_t              cmd,
    output gdad_status_t           status,
    input  logic [MONTH_WIDTH-1:0] start_month,
    input  logic [DAY_WIDTH-1:0]   start_day,
    input  logic [YEAR_WIDTH-1:0]  start_year,
    input  logic [DAYS_WIDTH-1:0]  day_count,
    output logic [MONTH_WIDTH-1:0] end_month,
    output logic [DAY_WIDTH-1:0]   end_day,
    output logic [YEAR_WIDTH-1:0]  end_year
);

    logic [MONTH_WIDTH-1:0] month_reg;
    logic [DAY_WIDTH-1:0]   day_reg;
    logic [YEAR_WIDTH-1:0]  year_reg;
    logic [LEFT_WIDTH-1:0]  left_reg;
    logic [QUOT_WIDTH-1:0]  quot_reg;
    logic [YMOD_WIDTH-1:0]  ymod_reg;
    logic [1:0]             cent_reg;

    logic [PROD_WIDTH-1:0]  prod;
    logic [YEAR_WIDTH-1:0]  hundreds;
    logic [YEAR_WIDTH-1:0]  rem_full;
    logic                   leap;
    logic [DAY_WIDTH-1:0]   len;
    logic signed [6:0]      to_end;
    logic signed [LEFT_WIDTH:0] left_s;
    logic signed [LEFT_WIDTH:0] to_end_s;
    logic signed [LEFT_WIDTH:0] diff;
    logic                   leave_month;

    assign prod     = PROD_WIDTH'(year_reg) * PROD_WIDTH'(DIV100_MUL);
    assign hundreds = YEAR_WIDTH'(quot_reg) * YEAR_WIDTH'(100);
    assign rem_full = year_reg - hundreds;

    // century years are leap only when the century count is a multiple of 4
    assign leap = (ymod_reg != '0) ? (year_reg[1:0] == 2'b00) : (cent_reg == 2'b00);
    assign len  = month_length(month_reg, leap);

    assign to_end   = $signed({2'b00, len}) - $signed({2'b00, day_reg}) + 7'sd1;
    assign left_s   = $signed({1'b0, left_reg});
    assign to_end_s = {{(LEFT_WIDTH - 6){to_end[6]}}, to_end};
    assign diff     = left_s - to_end_s;
    assign leave_month = (left_s >= to_end_s);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            month_reg <= start_month;
            day_reg   <= start_day;
            year_reg  <= start_year;
            left_reg  <= LEFT_WIDTH'(day_count);
        end
        else if (cmd.div)
        begin
            quot_reg <= prod[DIV100_SHIFT +: QUOT_WIDTH];
        end
        else if (cmd.rem)
        begin
            ymod_reg <= rem_full[YMOD_WIDTH-1:0];
            cent_reg <= quot_reg[1:0];
        end
        else if (cmd.step)
        begin
            if (leave_month)
            begin
                left_reg <= diff[LEFT_WIDTH-1:0];
                day_reg  <= DAY_WIDTH'(1);
                if (month_reg == MONTH_DEC)
                begin
                    month_reg <= MONTH_JAN;
                    year_reg  <= year_reg + YEAR_WIDTH'(1);
                    if (year_reg == YEAR_MAX)
                    begin
                        // wrap to year 0, a multiple of 400
                        ymod_reg <= '0;
                        cent_reg <= '0;
                    end
                    else if (ymod_reg == YMOD_LAST)
                    begin
                        ymod_reg <= '0;
                        cent_reg <= cent_reg + 2'd1;
                    end
                    else
                    begin
                        ymod_reg <= ymod_reg + YMOD_WIDTH'(1);
                    end
                end
                else if (month_reg > MONTH_DEC)
                begin
                    month_reg <= MONTH_JAN;
                end
                else
                begin
                    month_reg <= month_reg + MONTH_WIDTH'(1);
                end
            end
            else
            begin
                // count is below the distance to month end, so it fits a day
                day_reg  <= day_reg + left_reg[DAY_WIDTH-1:0];
                left_reg <= '0;
            end
        end
    end

    assign status.left_zero = (left_reg == '0);

    assign end_month = month_reg;
    assign end_day   = day_reg;
    assign end_year  = year_reg;

endmodule

@@ hdl/gdad_chk.sv @@
// ----------------------------------------------------------------------------
// gdad_chk
// Port-level checks on the date adder, bound to the top level.
// ----------------------------------------------------------------------------
module gdad_chk
    import gdad_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic [MONTH_WIDTH-1:0] start_month,
    input logic [DAY_WIDTH-1:0]   start_day,
    input logic [YEAR_WIDTH-1:0]  start_year,
    input logic [DAYS_WIDTH-1:0]  day_count,
    input logic                   done,
    input logic [MONTH_WIDTH-1:0] end_month,
    input logic [DAY_WIDTH-1:0]   end_day,
    input logic [YEAR_WIDTH-1:0]  end_year
);

    // a result beat only appears while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted beat did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done held longer than one cycle");

    // a zero count raises done with the start date unchanged
    a_zero_days: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && day_count == '0) |-> ##4
        (done && end_month == $past(start_month, 4)
              && end_day == $past(start_day, 4)
              && end_year == $past(start_year, 4)))
        else $error("zero-day item changed the date");

endmodule

bind gregorian_date_add_days_unit gdad_chk u_gdad_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .start_month (start_month),
    .start_day   (start_day),
    .start_year  (start_year),
    .day_count   (day_count),
    .done        (done),
    .end_month   (end_month),
    .end_day     (end_day),
    .end_year    (end_year)
);

@@ dv/tb_gregorian_date_add_days_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days_unit
// Drives dates and day counts into the date adder in random bursts. Each
// result is checked against a predictor that walks the calendar one month
// at a time. Some directed rows carry their expected date directly.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days_unit;
    import gdad_pkg::*;

    localparam int N_RANDOM    = 246;
    localparam int TAIL_CYCLES = 16;
    // generous bound for the slowest items (longest day counts) plus gaps
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [MONTH_WIDTH-1:0] month;
        logic [DAY_WIDTH-1:0]   day;
        logic [YEAR_WIDTH-1:0]  year;
    } date_t;

    typedef struct {
        date_t                 from;
        logic [DAYS_WIDTH-1:0] count;
        bit                    typed;
        date_t                 want;
    } date_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [MONTH_WIDTH-1:0] start_month;
    logic [DAY_WIDTH-1:0]   start_day;
    logic [YEAR_WIDTH-1:0]  start_year;
    logic [DAYS_WIDTH-1:0]  day_count;
    logic                   done;
    logic [MONTH_WIDTH-1:0] end_month;
    logic [DAY_WIDTH-1:0]   end_day;
    logic [YEAR_WIDTH-1:0]  end_year;

    // side info that travels with the beat on the start ports
    bit    row_typed;
    date_t row_want;

    date_t     pending_dates[$];
    date_row_t date_plan[$];
    int        error_count;
    int        items_taken;
    int        dates_checked;
    int        cycle_count;

    gregorian_date_add_days_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .start_month(start_month),
        .start_day  (start_day),
        .start_year (start_year),
        .day_count  (day_count),
        .done       (done),
        .end_month  (end_month),
        .end_day    (end_day),
        .end_year   (end_year)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d dates still pending",
                 cycle_count, pending_dates.size());
        $display("tb_gregorian_date_add_days_unit NOT OK");
        $finish;
    end

    function automatic bit leap_year_of(input int yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int month_days(input logic [MONTH_WIDTH-1:0] mon, input int yr);
        case (mon)
            4'd2:                      return leap_year_of(yr) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        return 31;
            default:                   return 0;
        endcase
    endfunction

    // Month-by-month walk; the remaining count may grow when the day is
    // past the month's end, so it is kept in a wide signed integer.
    function automatic date_t advance_date(input date_t from, input logic [DAYS_WIDTH-1:0] n);
        date_t                  to;
        logic [MONTH_WIDTH-1:0] mon;
        logic [YEAR_WIDTH-1:0]  yr;
        longint                 day;
        longint                 left;
        longint                 span;
        mon  = from.month;
        yr   = from.year;
        day  = from.day;
        left = n;
        while (left > 0)
        begin
            span = month_days(mon, yr) - day + 1;
            if (left >= span)
            begin
                left = left - span;
                day  = 1;
                if (mon == MONTH_DEC)
                begin
                    mon = MONTH_JAN;
                    yr  = yr + 1'b1;
                end
                else if (mon > MONTH_DEC)
                    mon = MONTH_JAN;
                else
                    mon = mon + 1'b1;
            end
            else
            begin
                day  = day + left;
                left = 0;
            end
        end
        to.month = mon;
        to.day   = day[DAY_WIDTH-1:0];
        to.year  = yr;
        return to;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic add_row(input int m, input int d, input int y, input int n,
                           input bit typed, input int wm, input int wd, input int wy);
        date_row_t r;
        r.from.month = MONTH_WIDTH'(m);
        r.from.day   = DAY_WIDTH'(d);
        r.from.year  = YEAR_WIDTH'(y);
        r.count      = DAYS_WIDTH'(n);
        r.typed      = typed;
        r.want.month = MONTH_WIDTH'(wm);
        r.want.day   = DAY_WIDTH'(wd);
        r.want.year  = YEAR_WIDTH'(wy);
        date_plan.push_back(r);
    endtask

    // holds the beat until the block takes it
    task automatic send_date(input date_row_t r);
        @(negedge clk);
        start       <= 1'b1;
        start_month <= r.from.month;
        start_day   <= r.from.day;
        start_year  <= r.from.year;
        day_count   <= r.count;
        row_typed   <= r.typed;
        row_want    <= r.want;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_pending();
        @(negedge clk);
        start <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        date_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_dates.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                              end_month, end_day, end_year));
                else
                begin
                    want = pending_dates.pop_front();
                    if (end_month !== want.month)
                        report_mismatch($sformatf("result %0d end_month %0d, want %0d",
                                                  dates_checked, end_month, want.month));
                    if (end_day !== want.day)
                        report_mismatch($sformatf("result %0d end_day %0d, want %0d",
                                                  dates_checked, end_day, want.day));
                    if (end_year !== want.year)
                        report_mismatch($sformatf("result %0d end_year %0d, want %0d",
                                                  dates_checked, end_year, want.year));
                    dates_checked++;
                end
            end
            if (start && !busy)
            begin
                if (row_typed)
                    pending_dates.push_back(row_want);
                else
                    pending_dates.push_back(advance_date({start_month, start_day, start_year},
                                                         day_count));
                items_taken++;
            end
        end
    end

    initial
    begin : stimulus
        date_row_t r;
        int        n_directed;
        int        n_long;
        int        burst_left;
        int        sel;
        int        yr;
        int        idx;

        rst_n         = 1'b0;
        start         = 1'b0;
        start_month   = '0;
        start_day     = '0;
        start_year    = '0;
        day_count     = '0;
        row_typed     = 1'b0;
        row_want      = '0;
        n_long        = 0;

        // month, day, year, count, typed, expected month/day/year
        add_row( 1,  1,  2000,     0, 1,  1,  1,  2000);
        add_row(15, 31, 16383,     0, 1, 15, 31, 16383);  // zero count, garbage date
        add_row(12, 31, 16383,     1, 1,  1,  1,     0);  // year wraps
        add_row( 2, 28,  2000,     1, 1,  2, 29,  2000);  // leap by 400
        add_row( 2, 28,  1900,     1, 1,  3,  1,  1900);  // century, not leap
        add_row( 2, 28,  2024,     1, 1,  2, 29,  2024);
        add_row( 2, 28,  2023,     1, 1,  3,  1,  2023);
        add_row( 1, 31,  2021,     1, 1,  2,  1,  2021);
        add_row(12,  1,  1999,    30, 1, 12, 31,  1999);
        add_row(12,  1,  1999,    31, 1,  1,  1,  2000);
        add_row( 1,  1,     0, 65535, 0,  0,  0,     0);
        add_row( 6, 31,  2021,     1, 0,  0,  0,     0);  // day past month end
        add_row( 2, 31,  2023,     3, 0,  0,  0,     0);
        add_row( 2, 29,  1900,     1, 0,  0,  0,     0);
        add_row( 3,  0,  2020,     5, 0,  0,  0,     0);  // day zero
        add_row( 0,  5,   100,     3, 0,  0,  0,     0);  // month zero
        add_row(13,  1,    50,     1, 0,  0,  0,     0);  // month above December
        add_row(15, 31, 16383, 65535, 0,  0,  0,     0);
        add_row( 0,  0, 16383, 65535, 0,  0,  0,     0);
        add_row( 2,  1,  2100,    28, 0,  0,  0,     0);
        add_row( 1,  1,     0,   366, 0,  0,  0,     0);
        add_row(10, 10, 12345, 32768, 0,  0,  0,     0);
        add_row( 5, 17,  8191,   255, 0,  0,  0,     0);
        add_row(12, 31,  1600,     1, 0,  0,  0,     0);
        n_directed = date_plan.size();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(0, 4))
                0:       yr = $urandom_range(0, 16383);
                1:       yr = $urandom_range(0, 163) * 100 + $urandom_range(0, 3);
                2:       yr = $urandom_range(1, 40) * 400 - $urandom_range(0, 2);
                3:       yr = 16383 - $urandom_range(0, 5);
                default: yr = $urandom_range(1890, 2110);
            endcase
            r.from.year = YEAR_WIDTH'(yr);
            if ($urandom_range(0, 99) < 85)
            begin
                r.from.month = MONTH_WIDTH'($urandom_range(1, 12));
                r.from.day   = DAY_WIDTH'($urandom_range(1, month_days(r.from.month, yr)));
            end
            else
            begin
                r.from.month = MONTH_WIDTH'($urandom_range(0, 15));
                r.from.day   = DAY_WIDTH'($urandom_range(0, 31));
            end
            sel = $urandom_range(0, 99);
            if (sel < 4)
                r.count = '0;
            else if (sel < 55)
                r.count = DAYS_WIDTH'($urandom_range(1, 400));
            else if (sel < 80)
                r.count = DAYS_WIDTH'($urandom_range(0, 4000));
            else if (sel < 96)
                r.count = DAYS_WIDTH'($urandom_range(0, 65535));
            else
                r.count = 16'hFFFF;
            if (r.count > 4000)
                n_long++;
            r.typed = 1'b0;
            r.want  = '0;
            date_plan.push_back(r);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        burst_left = 0;
        idx        = 0;
        foreach (date_plan[i])
        begin
            if (i == n_directed + N_RANDOM / 2)
                drain_pending();
            send_date(date_plan[i]);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                // roughly a third of bursts follow on with no gap
                if ($urandom_range(0, 2) != 0)
                    hold_off($urandom_range(1, 20));
            end
            else
                burst_left--;
        end

        drain_pending();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("took %0d dates (%0d directed, %0d random, %0d with counts past 4000)",
                 items_taken, n_directed, N_RANDOM, n_long);
        $display("compared %0d results in %0d cycles, %0d mismatches",
                 dates_checked, cycle_count, error_count);
        if (error_count == 0)
            $display("tb_gregorian_date_add_days_unit OK");
        else
            $display("tb_gregorian_date_add_days_unit NOT OK");
        $finish;
    end

endmodule
